// ===== src/m2e_pkg.sv =====
// Package for the rotation matrix to Euler angle converter.
// Holds widths, the arctangent step table, payload structs and latency.
// No dependencies.
package m2e_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int FRAC_IN        = DATA_WIDTH - 2;
  localparam int OUT_FRAC       = DATA_WIDTH - 3;
  localparam int ANG_FRAC       = 20;
  localparam int CORDIC_STEPS   = 20;
  localparam int PRESCALE_BITS  = 12;
  localparam int CW             = DATA_WIDTH + PRESCALE_BITS + 4;
  localparam int ZW             = ANG_FRAC + 4;
  localparam int ROUND_SHIFT    = ANG_FRAC - OUT_FRAC;
  localparam int ISQ_STEPS      = FRAC_IN + 1;
  localparam int ISQ_PER_STAGE  = 3;
  localparam int ISQ_STAGES     = (ISQ_STEPS + ISQ_PER_STAGE - 1) / ISQ_PER_STAGE;
  localparam int SQ_W           = 2 * FRAC_IN + 2;
  localparam int LATENCY        = 1 + ISQ_STAGES + CORDIC_STEPS + 2 + 1;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t row1_col1;
    elem_t row1_col2;
    elem_t row1_col3;
    elem_t row2_col2;
    elem_t row3_col1;
    elem_t row3_col2;
    elem_t row3_col3;
  } m2e_in_t;

  typedef struct packed {
    elem_t pitch_angle;
    elem_t yaw_angle;
    elem_t roll_angle;
    logic  regular;
  } m2e_out_t;

  // Operands that ride along the square root pipeline.
  typedef struct packed {
    logic  lock;
    logic  s_neg;
    elem_t s;
    elem_t roll_y;
    elem_t roll_x;
    elem_t yaw_y;
    elem_t yaw_x;
  } m2e_side_t;

  // atan(2^-i) in units of 2^-20 rad, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    case (idx)
      0:       atan_entry = ZW'(823550);
      1:       atan_entry = ZW'(486170);
      2:       atan_entry = ZW'(256879);
      3:       atan_entry = ZW'(130396);
      4:       atan_entry = ZW'(65451);
      5:       atan_entry = ZW'(32757);
      6:       atan_entry = ZW'(16383);
      7:       atan_entry = ZW'(8192);
      8:       atan_entry = ZW'(4096);
      9:       atan_entry = ZW'(2048);
      10:      atan_entry = ZW'(1024);
      11:      atan_entry = ZW'(512);
      12:      atan_entry = ZW'(256);
      13:      atan_entry = ZW'(128);
      14:      atan_entry = ZW'(64);
      15:      atan_entry = ZW'(32);
      16:      atan_entry = ZW'(16);
      17:      atan_entry = ZW'(8);
      18:      atan_entry = ZW'(4);
      19:      atan_entry = ZW'(2);
      default: atan_entry = '0;
    endcase
  endfunction

  localparam int HALF_PI_Z     = 2 * 823550;
  localparam int PITCH_LOCK_I  = (HALF_PI_Z + (1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
  localparam elem_t PITCH_LOCK = elem_t'(PITCH_LOCK_I);

endpackage

// ===== src/m2e_isqrt.sv =====
// Pipelined integer square root, three result bits per stage.
// Carries a sideband word alongside. Depends on m2e_pkg.
module m2e_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [m2e_pkg::SQ_W-1:0]   in_rem,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [m2e_pkg::FRAC_IN:0]  out_root,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int NS = m2e_pkg::ISQ_STAGES;
  localparam int W  = m2e_pkg::SQ_W;

  logic [NS-1:0] vld_r;
  logic [W-1:0]  v_r    [NS];
  logic [W-1:0]  r_r    [NS];
  logic [SIDE_W-1:0] side_r [NS];

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_stage
      logic [W-1:0] v_in, r_in, v_nxt, r_nxt;
      logic [SIDE_W-1:0] side_in;
      logic valid_in;

      if (g == 0) begin : g_first
        assign v_in     = in_rem;
        assign r_in     = '0;
        assign side_in  = in_side;
        assign valid_in = in_valid;
      end else begin : g_rest
        assign v_in     = v_r[g-1];
        assign r_in     = r_r[g-1];
        assign side_in  = side_r[g-1];
        assign valid_in = vld_r[g-1];
      end

      always_comb begin : calc
        logic [W-1:0] v, r, b, t;
        int k;
        v = v_in;
        r = r_in;
        for (int j = 0; j < m2e_pkg::ISQ_PER_STAGE; j++) begin
          k = g * m2e_pkg::ISQ_PER_STAGE + j;
          if (k < m2e_pkg::ISQ_STEPS) begin
            b = W'(1) << (2 * (m2e_pkg::ISQ_STEPS - 1 - k));
            t = r + b;
            if (v >= t) begin
              v = v - t;
              r = (r >> 1) + b;
            end else begin
              r = r >> 1;
            end
          end
        end
        v_nxt = v;
        r_nxt = r;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else begin
          vld_r[g] <= valid_in;
        end
      end

      always_ff @(posedge clk) begin
        v_r[g]    <= v_nxt;
        r_r[g]    <= r_nxt;
        side_r[g] <= side_in;
      end
    end
  endgenerate

  assign out_valid = vld_r[NS-1];
  assign out_root  = r_r[NS-1][m2e_pkg::FRAC_IN:0];
  assign out_side  = side_r[NS-1];

endmodule

// ===== src/m2e_cordic.sv =====
// Pipelined vectoring CORDIC atan2: fold stage, one stage per step, rounding.
// Carries a sideband word alongside. Depends on m2e_pkg.
module m2e_cordic #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  m2e_pkg::elem_t        in_y,
  input  m2e_pkg::elem_t        in_x,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output m2e_pkg::elem_t        out_angle,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int DW = m2e_pkg::DATA_WIDTH;
  localparam int CW = m2e_pkg::CW;
  localparam int ZW = m2e_pkg::ZW;
  localparam int NS = m2e_pkg::CORDIC_STEPS;

  logic [NS:0]              vld_r;
  logic signed [CW-1:0]     x_r    [NS+1];
  logic signed [CW-1:0]     y_r    [NS+1];
  logic signed [ZW-1:0]     z_r    [NS+1];
  logic [NS:0]              zero_r;
  logic [SIDE_W-1:0]        side_r [NS+1];

  logic signed [CW-1:0] xs, ys, x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;

  assign xs = {{(CW-DW){in_x[DW-1]}}, in_x} <<< m2e_pkg::PRESCALE_BITS;
  assign ys = {{(CW-DW){in_y[DW-1]}}, in_y} <<< m2e_pkg::PRESCALE_BITS;

  // A negative x is turned by a quarter turn into the right half plane.
  always_comb begin
    x0_nxt = xs;
    y0_nxt = ys;
    z0_nxt = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0_nxt = ys;
        y0_nxt = -xs;
        z0_nxt = ZW'(m2e_pkg::HALF_PI_Z);
      end else begin
        x0_nxt = -ys;
        y0_nxt = xs;
        z0_nxt = -ZW'(m2e_pkg::HALF_PI_Z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= x0_nxt;
    y_r[0]    <= y0_nxt;
    z_r[0]    <= z0_nxt;
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    side_r[0] <= in_side;
  end

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_step
      logic signed [CW-1:0] dx, dy;
      assign dx = y_r[i] >>> i;
      assign dy = x_r[i] >>> i;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i+1] <= 1'b0;
        end else begin
          vld_r[i+1] <= vld_r[i];
        end
      end

      always_ff @(posedge clk) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + m2e_pkg::atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - m2e_pkg::atan_entry(i);
        end
        zero_r[i+1] <= zero_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  endgenerate

  logic signed [ZW-1:0] z_round;
  logic                 vout_r;
  m2e_pkg::elem_t       ang_r;
  logic [SIDE_W-1:0]    sout_r;

  assign z_round = (z_r[NS] + ZW'(1 << (m2e_pkg::ROUND_SHIFT - 1))) >>> m2e_pkg::ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    ang_r  <= zero_r[NS] ? '0 : z_round[DW-1:0];
    sout_r <= side_r[NS];
  end

  assign out_valid = vout_r;
  assign out_angle = ang_r;
  assign out_side  = sout_r;

endmodule

// ===== src/matrix_to_euler_angles.sv =====
// Rotation matrix to Z-X-Y Euler angles: pitch, yaw, roll and a regular flag.
// An accepted start passes the front stage, the square root, the CORDIC units and the output register to out_valid.
// Throughput is one item per cycle; busy is low whenever out of reset.
// The square root pipeline and three CORDIC units set the depth.
// Synchronous active-low reset empties the pipeline; busy is high during it.
module matrix_to_euler_angles (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  m2e_pkg::m2e_in_t  in_data,
  output logic              out_valid,
  output m2e_pkg::m2e_out_t out_data
);

  localparam int DW   = m2e_pkg::DATA_WIDTH;
  localparam int SW   = m2e_pkg::SQ_W;
  localparam int SIDE = $bits(m2e_pkg::m2e_side_t);

  // Front stage: negate and clamp the pitch element, square it.
  logic signed [DW:0]     s_neg_full, s_clamp;
  logic signed [2*DW+1:0] s_sq;
  logic                   lock;
  logic                   acc;

  assign busy = !rst_n;
  assign acc  = start && !busy;

  assign s_neg_full = -{in_data.row3_col2[DW-1], in_data.row3_col2};

  always_comb begin
    s_clamp = s_neg_full;
    if (s_neg_full > (DW+1)'(1 << m2e_pkg::FRAC_IN)) begin
      s_clamp = (DW+1)'(1 << m2e_pkg::FRAC_IN);
    end else if (s_neg_full < -(DW+1)'(1 << m2e_pkg::FRAC_IN)) begin
      s_clamp = -(DW+1)'(1 << m2e_pkg::FRAC_IN);
    end
  end

  assign lock = (s_clamp == (DW+1)'(1 << m2e_pkg::FRAC_IN)) ||
                (s_clamp == -(DW+1)'(1 << m2e_pkg::FRAC_IN));
  assign s_sq = s_clamp * s_clamp;

  logic               fvld_r;
  logic [SW-1:0]      rem_r;
  m2e_pkg::m2e_side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r <= 1'b0;
    end else begin
      fvld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    rem_r         <= (SW'(1) << (2 * m2e_pkg::FRAC_IN)) - s_sq[SW-1:0];
    side_r.lock   <= lock;
    side_r.s_neg  <= s_clamp[DW];
    side_r.s      <= s_clamp[DW-1:0];
    side_r.roll_y <= lock ? in_data.row1_col3 : in_data.row1_col2;
    side_r.roll_x <= lock ? in_data.row1_col1 : in_data.row2_col2;
    side_r.yaw_y  <= in_data.row3_col1;
    side_r.yaw_x  <= in_data.row3_col3;
  end

  logic                      sq_vld;
  logic [m2e_pkg::FRAC_IN:0] sq_root;
  logic [SIDE-1:0]           sq_side_raw;
  m2e_pkg::m2e_side_t        sq_side;

  m2e_isqrt #(.SIDE_W(SIDE)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fvld_r),
    .in_rem    (rem_r),
    .in_side   (side_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side_raw)
  );

  assign sq_side = m2e_pkg::m2e_side_t'(sq_side_raw);

  logic           p_vld, y_vld, r_vld;
  m2e_pkg::elem_t p_ang, y_ang, r_ang;
  logic [1:0]     p_side;
  logic           y_side, r_side;

  m2e_cordic #(.SIDE_W(2)) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_vld),
    .in_y      (sq_side.s),
    .in_x      (DW'(sq_root)),
    .in_side   ({sq_side.lock, sq_side.s_neg}),
    .out_valid (p_vld),
    .out_angle (p_ang),
    .out_side  (p_side)
  );

  m2e_cordic #(.SIDE_W(1)) u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_vld),
    .in_y      (sq_side.yaw_y),
    .in_x      (sq_side.yaw_x),
    .in_side   (sq_side.lock),
    .out_valid (y_vld),
    .out_angle (y_ang),
    .out_side  (y_side)
  );

  m2e_cordic #(.SIDE_W(1)) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_vld),
    .in_y      (sq_side.roll_y),
    .in_x      (sq_side.roll_x),
    .in_side   (sq_side.lock && sq_side.s_neg),
    .out_valid (r_vld),
    .out_angle (r_ang),
    .out_side  (r_side)
  );

  logic              ovld_r;
  m2e_pkg::m2e_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= p_vld && y_vld && r_vld;
    end
  end

  // At gimbal lock pitch is a signed quarter turn and yaw is forced to zero.
  always_ff @(posedge clk) begin
    if (p_side[1]) begin
      out_r.pitch_angle <= p_side[0] ? -m2e_pkg::PITCH_LOCK : m2e_pkg::PITCH_LOCK;
    end else begin
      out_r.pitch_angle <= p_ang;
    end
    out_r.yaw_angle  <= y_side ? '0 : y_ang;
    out_r.roll_angle <= r_side ? -r_ang : r_ang;
    out_r.regular    <= !p_side[1];
  end

  assign out_valid = ovld_r;
  assign out_data  = out_r;

endmodule

// ===== src/m2e_checker.sv =====
// Port-level checks for matrix_to_euler_angles, bound to the top level.
// Depends on m2e_pkg.
module m2e_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input m2e_pkg::m2e_out_t out_data,
  input logic              out_valid
);

  localparam int LAT = m2e_pkg::LATENCY;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted item produced no result");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result without accepted item");

  a_lock_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.regular) |-> (out_data.yaw_angle == '0))
    else $error("yaw not zero at gimbal lock");

  a_lock_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.regular) |->
      ((out_data.pitch_angle == m2e_pkg::PITCH_LOCK) ||
       (out_data.pitch_angle == -m2e_pkg::PITCH_LOCK)))
    else $error("pitch not a quarter turn at gimbal lock");

endmodule

bind matrix_to_euler_angles m2e_checker u_m2e_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);
